>>> sv/assert_macros.svh
// Assertion macros for the checker file of the line rasterizer (clr_checker.sv).
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition in one cycle brings a condition in the next.
`define CLR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> sv/clr_pkg.sv
// Shared types and constants of the clamped line rasterizer.
// No dependencies; the other source files but assert_macros.svh refer to it by scoped names.
package clr_pkg;

   // Widths of the transaction fields
   localparam int COORD_IN_W = 16;
   localparam int PIX_W      = 6;

   // Default picture size
   localparam int PIC_WIDTH_DEF  = 64;
   localparam int PIC_HEIGHT_DEF = 64;

   // Controller states
   typedef enum logic [1:0] {
      CLR_IDLE,
      CLR_SETUP,
      CLR_RUN
   } clr_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic step;
   } clr_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic span_zero;
      logic last;
   } clr_stat_type;

endpackage

>>> sv/clr_ifs.sv
// Valid/ready channel interfaces for line commands and pixel results.
// Depends on clr_pkg for field widths.
interface clr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [clr_pkg::COORD_IN_W-1:0]  start_x;
   logic signed [clr_pkg::COORD_IN_W-1:0]  start_y;
   logic signed [clr_pkg::COORD_IN_W-1:0]  end_x;
   logic signed [clr_pkg::COORD_IN_W-1:0]  end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [clr_pkg::PIX_W-1:0]   pixel_x;
   logic [clr_pkg::PIX_W-1:0]   pixel_y;
   logic                        last_pixel;

   modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

>>> sv/clr_ctrl.sv
// Controller of the line rasterizer: sequences capture, setup and pixel stepping.
// Depends on clr_pkg for the state, command and status types.
module clr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  clr_pkg::clr_stat_type stat,
   output clr_pkg::clr_cmd_type  cmd
);

   clr_pkg::clr_state_type state_ff, state_in;

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clr_pkg::CLR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decide next state and drive commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         clr_pkg::CLR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = clr_pkg::CLR_SETUP;
            end
         end
         clr_pkg::CLR_SETUP: begin
            // drop lines whose clamped endpoints coincide
            if (stat.span_zero) begin
               state_in = clr_pkg::CLR_IDLE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = clr_pkg::CLR_RUN;
            end
         end
         clr_pkg::CLR_RUN: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.last) begin
                  state_in = clr_pkg::CLR_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = clr_pkg::CLR_IDLE;
         end
      endcase
   end

endmodule

>>> sv/clr_datapath.sv
// Datapath of the line rasterizer: clamping, axis choice and error-term stepping.
// Depends on clr_pkg for widths and the command and status types.
module clr_datapath #(
   parameter int PIC_WIDTH  = clr_pkg::PIC_WIDTH_DEF,
   parameter int PIC_HEIGHT = clr_pkg::PIC_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic signed [clr_pkg::COORD_IN_W-1:0] start_x,
   input  logic signed [clr_pkg::COORD_IN_W-1:0] start_y,
   input  logic signed [clr_pkg::COORD_IN_W-1:0] end_x,
   input  logic signed [clr_pkg::COORD_IN_W-1:0] end_y,
   input  clr_pkg::clr_cmd_type                  cmd,
   output clr_pkg::clr_stat_type                 stat,
   output logic [clr_pkg::PIX_W-1:0]             pixel_x,
   output logic [clr_pkg::PIX_W-1:0]             pixel_y,
   output logic                                  last_pixel
);

   localparam int PW = clr_pkg::PIX_W;
   localparam int CW = clr_pkg::COORD_IN_W;
   localparam logic signed [CW-1:0] X_TOP = CW'(PIC_WIDTH - 1);
   localparam logic signed [CW-1:0] Y_TOP = CW'(PIC_HEIGHT - 1);

   function automatic logic [PW-1:0] clamp_coord(input logic signed [CW-1:0] v,
                                                 input logic signed [CW-1:0] top);
      logic [PW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > top) begin
         r = top[PW-1:0];
      end else begin
         r = v[PW-1:0];
      end
      return r;
   endfunction

   // Clamped endpoints
   logic [PW-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   // Stepping state
   logic [PW-1:0]        maj_ff, min_ff, maj_end_ff, span_ff, rem_ff;
   logic signed [PW:0]   mdelta_ff;
   logic                 ymaj_ff;

   // Setup terms
   logic signed [PW:0] dx, dy, adx, ady;
   logic               ymaj;
   logic [PW-1:0]      a0, a1, b0, b1, maj_s, maj_e, min_s, min_e;
   logic               swap;

   // Step terms
   logic signed [PW+1:0] rsum, span_s;
   logic [PW-1:0]        rem_in, min_in;

   // Capture clamped endpoints
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= clamp_coord(start_x, X_TOP);
         y0_ff <= clamp_coord(start_y, Y_TOP);
         x1_ff <= clamp_coord(end_x, X_TOP);
         y1_ff <= clamp_coord(end_y, Y_TOP);
      end
   end

   // Choose major axis and order endpoints low to high
   always_comb begin
      dx    = $signed({1'b0, x1_ff}) - $signed({1'b0, x0_ff});
      dy    = $signed({1'b0, y1_ff}) - $signed({1'b0, y0_ff});
      adx   = (dx < 0) ? -dx : dx;
      ady   = (dy < 0) ? -dy : dy;
      ymaj  = ady > adx;
      a0    = ymaj ? y0_ff : x0_ff;
      a1    = ymaj ? y1_ff : x1_ff;
      b0    = ymaj ? x0_ff : y0_ff;
      b1    = ymaj ? x1_ff : y1_ff;
      swap  = a1 < a0;
      maj_s = swap ? a1 : a0;
      maj_e = swap ? a0 : a1;
      min_s = swap ? b1 : b0;
      min_e = swap ? b0 : b1;
   end

   // Advance the remainder; one correction keeps it in 0..span-1
   always_comb begin
      span_s = $signed({2'b00, span_ff});
      rsum   = $signed({2'b00, rem_ff}) + {mdelta_ff[PW], mdelta_ff};
      rem_in = rsum[PW-1:0];
      min_in = min_ff;
      if (rsum >= span_s) begin
         rem_in = PW'(rsum - span_s);
         min_in = min_ff + PW'(1);
      end else if (rsum < 0) begin
         rem_in = PW'(rsum + span_s);
         min_in = min_ff - PW'(1);
      end
   end

   // Load setup or step one pixel
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         maj_ff     <= maj_s;
         min_ff     <= min_s;
         maj_end_ff <= maj_e;
         span_ff    <= maj_e - maj_s;
         mdelta_ff  <= $signed({1'b0, min_e}) - $signed({1'b0, min_s});
         rem_ff     <= '0;
         ymaj_ff    <= ymaj;
      end else if (cmd.step) begin
         maj_ff <= maj_ff + PW'(1);
         min_ff <= min_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.span_zero = (x0_ff == x1_ff) && (y0_ff == y1_ff);
   assign stat.last      = (maj_ff == maj_end_ff);

   assign pixel_x    = ymaj_ff ? min_ff : maj_ff;
   assign pixel_y    = ymaj_ff ? maj_ff : min_ff;
   assign last_pixel = stat.last;

endmodule

>>> sv/clamped_line_rasterizer_core.sv
// Top level of the clamped line rasterizer: controller plus datapath.
// Depends on clr_pkg, clr_ifs (channel interfaces), clr_ctrl and clr_datapath.
//
//   channel    direction  carries
//   req_chan   in         one line command: start_x, start_y, end_x, end_y
//   rsp_chan   out        one pixel per transaction: pixel_x, pixel_y, last_pixel
//
// A line runs in order: accept, a setup state, then one pixel per cycle along
// the major axis while rsp_ready is high (span + 1 pixels, at most 64), set by
// the single error-term stepper. A line with coinciding clamped endpoints gives
// nothing. One line is in work at a time; a stalled pixel holds. Reset is
// synchronous and returns the controller to idle.
module clamped_line_rasterizer_core #(
   parameter int PIC_WIDTH  = clr_pkg::PIC_WIDTH_DEF,
   parameter int PIC_HEIGHT = clr_pkg::PIC_HEIGHT_DEF
) (
   input logic        clock,
   input logic        reset,
   clr_req_if.sink    req_chan,
   clr_rsp_if.source  rsp_chan
);

   clr_pkg::clr_cmd_type  cmd;
   clr_pkg::clr_stat_type stat;

   clr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clr_datapath #(
      .PIC_WIDTH  (PIC_WIDTH),
      .PIC_HEIGHT (PIC_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .start_x    (req_chan.start_x),
      .start_y    (req_chan.start_y),
      .end_x      (req_chan.end_x),
      .end_y      (req_chan.end_y),
      .cmd        (cmd),
      .stat       (stat),
      .pixel_x    (rsp_chan.pixel_x),
      .pixel_y    (rsp_chan.pixel_y),
      .last_pixel (rsp_chan.last_pixel)
   );

endmodule

>>> sv/clr_checker.sv
// Port-level checks of the clamped line rasterizer, bound to the top level.
// Depends on clr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clr_checker #(
   parameter int PIC_WIDTH  = clr_pkg::PIC_WIDTH_DEF,
   parameter int PIC_HEIGHT = clr_pkg::PIC_HEIGHT_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [clr_pkg::PIX_W-1:0] pixel_x,
   input logic [clr_pkg::PIX_W-1:0] pixel_y,
   input logic                      last_pixel
);

   localparam logic [clr_pkg::PIX_W:0] W_LIM = (clr_pkg::PIX_W + 1)'(PIC_WIDTH);
   localparam logic [clr_pkg::PIX_W:0] H_LIM = (clr_pkg::PIX_W + 1)'(PIC_HEIGHT);

   // Hold a pixel until it is taken
   `CLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "pixel dropped while stalled")

   // Take no new line while pixels are pending
   `CLR_ASSERT(a_one_line, clock, reset, !(req_ready && rsp_valid), "command taken during a line")

   // Pass through setup after a command, with neither channel active
   `CLR_ASSERT_NEXT(a_setup_gap, clock, reset, req_valid && req_ready, !rsp_valid && !req_ready, "no setup cycle after command")

   // Continue the line until the final pixel
   `CLR_ASSERT_NEXT(a_no_gap, clock, reset, rsp_valid && rsp_ready && !last_pixel, rsp_valid, "line broken before its final pixel")

   // Keep every pixel inside the picture
   `CLR_ASSERT(a_in_pic, clock, reset, !rsp_valid || (({1'b0, pixel_x} < W_LIM) && ({1'b0, pixel_y} < H_LIM)), "pixel outside picture")

endmodule

bind clamped_line_rasterizer_core clr_checker #(
   .PIC_WIDTH  (PIC_WIDTH),
   .PIC_HEIGHT (PIC_HEIGHT)
) u_clr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .pixel_x    (rsp_chan.pixel_x),
   .pixel_y    (rsp_chan.pixel_y),
   .last_pixel (rsp_chan.last_pixel)
);
